FILE: rtl/core/lelh_pkg.sv
// Shared types and codes for the lower envelope line hull.
// Used by lelh_ctrl, lelh_dpath and lower_envelope_line_hull_top.
package lelh_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_ANSWER = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_ORDER  = 3'd4;

  typedef enum logic [1:0] {
    RD_POP  = 2'd0,
    RD_MID  = 2'd1,
    RD_NEXT = 2'd2,
    RD_PREV = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic       load_item;
    logic       clear;
    logic       push;
    logic       pop;
    logic       load_r1;
    logic       exit_add;
    logic       mul_a;
    logic       mul_b;
    logic       q_init;
    logic       q_mid;
    logic       q_here;
    logic       q_nb;
    logic       q_lo;
    logic       q_hi;
    rd_sel_t    rd_sel;
    logic       load_out;
    logic [2:0] out_code;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       order_bad;
    logic       full;
    logic       empty;
    logic       ge3;
    logic       redundant;
    logic       next_less;
    logic       has_prev;
    logic       prev_less;
    logic       probe_last;
    logic       out_free;
  } sts_t;

endpackage

FILE: rtl/core/lelh_dpath.sv
// Datapath of the line hull: line memory, triple and top registers, shared
// multiplier, search bounds and result register. Depends on lelh_pkg.
module lelh_dpath import lelh_pkg::*; #(
  parameter int HULL_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  output sts_t               sts,
  input  logic [1:0]         command,
  input  logic signed [31:0] line_slope,
  input  logic signed [31:0] line_intercept,
  input  logic signed [31:0] query_x,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] min_value,
  output logic [2:0]         status,
  output logic [10:0]        hull_size
);

  localparam int CW = $clog2(HULL_DEPTH + 1);
  localparam int AW = $clog2(HULL_DEPTH);

  logic [63:0] mem [HULL_DEPTH];
  logic [63:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0] wr_data;
  logic        wr_en;

  logic [1:0]         cmd;
  logic signed [31:0] new_m, new_b, qx;
  logic signed [31:0] top_m, top_b, sub_m, sub_b;
  logic signed [31:0] m1, b1, m2, b2, m3, b3;
  logic [CW-1:0]      count;
  logic [CW-1:0]      lo, hi, mid;
  logic [5:0]         probe;
  logic signed [65:0] prod_a, prod_b;
  logic signed [63:0] here, nb;

  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid_c;
  logic [CW:0]        mid_inc;
  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;
  logic signed [63:0] line_val;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_c   = mid_sum[CW:1];
  assign mid_inc = {1'b0, mid} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    case (ctl.rd_sel)
      RD_POP:  rd_addr = AW'(count - CW'(3));
      RD_MID:  rd_addr = AW'(mid_c);
      RD_NEXT: rd_addr = AW'(mid_inc);
      RD_PREV: rd_addr = AW'(mid - CW'(1));
      default: rd_addr = AW'(mid_c);
    endcase
  end

  always_comb begin
    wr_en   = ctl.push | ctl.pop;
    wr_addr = ctl.pop ? AW'(count - CW'(2)) : AW'(count);
    wr_data = ctl.pop ? {m3, b3} : {new_m, new_b};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // one shared multiplier: cross products of the hull test, or slope times x
  always_comb begin
    if (ctl.mul_a) begin
      op_a = 33'(b3) - 33'(b1);
      op_b = 33'(m1) - 33'(m2);
    end else if (ctl.mul_b) begin
      op_a = 33'(b2) - 33'(b1);
      op_b = 33'(m1) - 33'(m3);
    end else begin
      op_a = 33'(signed'(rd_data[63:32]));
      op_b = 33'(qx);
    end
    prod     = op_a * op_b;
    line_val = prod[63:0] + (64'(signed'(rd_data[31:0])) <<< 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        count <= '0;
      end else if (ctl.push) begin
        count <= count + CW'(1);
      end else if (ctl.pop) begin
        count <= count - CW'(1);
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd   <= command;
      new_m <= line_slope;
      new_b <= line_intercept;
      qx    <= query_x;
    end
    if (ctl.push) begin
      m1 <= sub_m;
      b1 <= sub_b;
      m2 <= top_m;
      b2 <= top_b;
      m3 <= new_m;
      b3 <= new_b;
    end
    if (ctl.pop) begin
      m2 <= m1;
      b2 <= b1;
    end
    if (ctl.load_r1) begin
      m1 <= signed'(rd_data[63:32]);
      b1 <= signed'(rd_data[31:0]);
    end
    if (ctl.exit_add) begin
      sub_m <= m2;
      sub_b <= b2;
      top_m <= m3;
      top_b <= b3;
    end
    if (ctl.mul_a) begin
      prod_a <= prod;
    end
    if (ctl.mul_b) begin
      prod_b <= prod;
    end
    if (ctl.q_init) begin
      lo    <= '0;
      hi    <= count - CW'(1);
      probe <= '0;
    end
    if (ctl.q_mid) begin
      mid <= mid_c;
    end
    if (ctl.q_here) begin
      here <= line_val;
    end
    if (ctl.q_nb) begin
      nb <= line_val;
    end
    if (ctl.q_lo) begin
      lo    <= CW'(mid_inc);
      probe <= probe + 6'd1;
    end
    if (ctl.q_hi) begin
      hi    <= mid - CW'(1);
      probe <= probe + 6'd1;
    end
    if (ctl.load_out) begin
      min_value <= (ctl.out_code == ST_ANSWER) ? here : 64'sd0;
      status    <= ctl.out_code;
      hull_size <= 11'(count);
    end
  end

  always_comb begin
    sts.cmd        = cmd;
    sts.order_bad  = (count != '0) && (new_m > top_m);
    sts.full       = (count == CW'(HULL_DEPTH));
    sts.empty      = (count == '0);
    sts.ge3        = (count >= CW'(3));
    sts.redundant  = (prod_a <= prod_b);
    sts.next_less  = (mid_inc < {1'b0, count}) && (nb < here);
    sts.has_prev   = (mid != '0);
    sts.prev_less  = (nb < here);
    sts.probe_last = (probe == 6'd63);
    sts.out_free   = !out_valid || !out_stall;
  end

endmodule

FILE: rtl/core/lelh_ctrl.sv
// Sequencer of the line hull: decodes an item and steps the datapath
// through push, redundancy pops and the binary search. Depends on lelh_pkg.
module lelh_ctrl import lelh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_DECODE  = 15'b000000000000010,
    S_CHK     = 15'b000000000000100,
    S_RED_A   = 15'b000000000001000,
    S_RED_B   = 15'b000000000010000,
    S_RED_CMP = 15'b000000000100000,
    S_POP_RD  = 15'b000000001000000,
    S_POP_WT  = 15'b000000010000000,
    S_Q_RD    = 15'b000000100000000,
    S_Q_HERE  = 15'b000001000000000,
    S_Q_NEXT  = 15'b000010000000000,
    S_Q_CMPN  = 15'b000100000000000,
    S_Q_PREV  = 15'b001000000000000,
    S_Q_CMPP  = 15'b010000000000000,
    S_FIN     = 15'b100000000000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_DONE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    code_next    = code;
    ctl          = '0;
    ctl.rd_sel   = RD_MID;
    ctl.out_code = code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        code_next  = ST_DONE;
        state_next = S_FIN;
        case (sts.cmd)
          CMD_CLEAR: ctl.clear = 1'b1;
          CMD_ADD: begin
            if (sts.order_bad) begin
              code_next = ST_ORDER;
            end else if (sts.full) begin
              code_next = ST_FULL;
            end else begin
              ctl.push   = 1'b1;
              state_next = S_CHK;
            end
          end
          CMD_QUERY: begin
            if (sts.empty) begin
              code_next = ST_EMPTY;
            end else begin
              ctl.q_init = 1'b1;
              code_next  = ST_ANSWER;
              state_next = S_Q_RD;
            end
          end
          default: code_next = ST_DONE;
        endcase
      end
      S_CHK: begin
        if (sts.ge3) begin
          state_next = S_RED_A;
        end else begin
          ctl.exit_add = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_RED_A: begin
        ctl.mul_a  = 1'b1;
        state_next = S_RED_B;
      end
      S_RED_B: begin
        ctl.mul_b  = 1'b1;
        state_next = S_RED_CMP;
      end
      S_RED_CMP: begin
        if (sts.redundant) begin
          ctl.pop    = 1'b1;
          state_next = S_POP_RD;
        end else begin
          ctl.exit_add = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_POP_RD: begin
        // fetch the line that becomes the bottom of the next triple
        ctl.rd_sel = RD_POP;
        state_next = S_POP_WT;
      end
      S_POP_WT: begin
        ctl.load_r1 = 1'b1;
        state_next  = S_CHK;
      end
      S_Q_RD: begin
        ctl.q_mid  = 1'b1;
        ctl.rd_sel = RD_MID;
        state_next = S_Q_HERE;
      end
      S_Q_HERE: begin
        ctl.q_here = 1'b1;
        ctl.rd_sel = RD_NEXT;
        state_next = S_Q_NEXT;
      end
      S_Q_NEXT: begin
        ctl.q_nb   = 1'b1;
        state_next = S_Q_CMPN;
      end
      S_Q_CMPN: begin
        if (sts.next_less) begin
          ctl.q_lo   = 1'b1;
          state_next = sts.probe_last ? S_FIN : S_Q_RD;
        end else if (sts.has_prev) begin
          ctl.rd_sel = RD_PREV;
          state_next = S_Q_PREV;
        end else begin
          state_next = S_FIN;
        end
      end
      S_Q_PREV: begin
        ctl.q_nb   = 1'b1;
        state_next = S_Q_CMPP;
      end
      S_Q_CMPP: begin
        if (sts.prev_less) begin
          ctl.q_hi   = 1'b1;
          state_next = sts.probe_last ? S_FIN : S_Q_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the result register is free
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/lower_envelope_line_hull_top.sv
// Top level of the lower envelope line hull; joins lelh_ctrl and lelh_dpath.
// Depends on lelh_pkg.
//
// Keeps a stack of lines (Q16.16 slope and intercept) forming the lower
// envelope for minimum queries. One item is worked on at a time; the result
// register lets the next item in while a result waits. Clear and rejected
// adds go straight to the finish; an add pushes the line, runs the hull test
// when there are three or more lines, and for each line popped reads the line
// memory once before the hull test runs again.
// A query runs a binary search of at most floor(log2(hull_size)) + 1 probe
// steps; each step reads the probed line and its next neighbor, and the
// previous neighbor when needed, from the line memory.
// A stalled result holds the next item at its finish until it is taken.
module lower_envelope_line_hull_top import lelh_pkg::*; #(
  parameter int HULL_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] line_slope,
  input  logic signed [31:0] line_intercept,
  input  logic signed [31:0] query_x,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] min_value,
  output logic [2:0]         status,
  output logic [10:0]        hull_size
);

  ctl_t ctl;
  sts_t sts;

  lelh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  lelh_dpath #(
    .HULL_DEPTH (HULL_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .command        (command),
    .line_slope     (line_slope),
    .line_intercept (line_intercept),
    .query_x        (query_x),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .min_value      (min_value),
    .status         (status),
    .hull_size      (hull_size)
  );

endmodule
